### hw/rtl/pcps_pkg.sv
// Shared codes and control types for the pulse-count position/stop controller.
// No dependencies; imported by every module of the block except pcps_fifo.
package pcps_pkg;

  localparam int unsigned POS_WIDTH_DEFAULT = 16;
  localparam int unsigned TARGET_IN_WIDTH   = 16;
  localparam int unsigned CMD_DEPTH         = 2;
  localparam int unsigned RES_DEPTH         = 2;

  // input mode codes
  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_TARGET = 3'd1;
  localparam logic [2:0] MODE_MOTION = 3'd2;
  localparam logic [2:0] MODE_LIMIT  = 3'd3;
  localparam logic [2:0] MODE_REZERO = 3'd4;

  // motion codes
  localparam logic [1:0] MOT_STOP = 2'd0;
  localparam logic [1:0] MOT_INC  = 2'd1;
  localparam logic [1:0] MOT_DEC  = 2'd2;

  // limit event codes
  localparam logic [1:0] LEV_NONE   = 2'd0;
  localparam logic [1:0] LEV_LIMIT  = 2'd1;
  localparam logic [1:0] LEV_REZERO = 2'd2;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_TARGET,
    OP_MOTION,
    OP_LIMIT,
    OP_REZERO,
    OP_NOP
  } op_e;

  // decoded request, minus the target value
  typedef struct packed {
    op_e        op;
    logic       sense;
    logic [1:0] motion;
  } cmd_ctl_t;

  // per-result flags and motion
  typedef struct packed {
    logic [1:0] motion;
    logic       moving;
    logic       pos_ev;
    logic       mot_ev;
    logic       tgt_ev;
    logic [1:0] lim_ev;
  } res_flags_t;

endpackage

### hw/rtl/pcps_fifo.sv
// Small register FIFO used for the request queue and the result queue.
// Depends on nothing but its parameters; payload type is a parameter.
module pcps_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PW-1:0]   wptr_q, rptr_q;
  logic [CW-1:0]   count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/pcps_front.sv
// Front end: decodes incoming requests, saturates the target and queues them.
// Depends on pcps_pkg and pcps_fifo.
module pcps_front
  import pcps_pkg::*;
#(
  parameter int unsigned POS_WIDTH = POS_WIDTH_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [2:0]                  mode_i,
  input  logic                        sense_level_i,
  input  logic signed [TARGET_IN_WIDTH-1:0] target_value_i,
  input  logic [1:0]                  new_motion_i,
  input  logic                        pop_i,
  output logic                        empty_o,
  output cmd_ctl_t                    ctl_o,
  output logic signed [POS_WIDTH-1:0] tgt_o
);

  typedef struct packed {
    cmd_ctl_t                    ctl;
    logic signed [POS_WIDTH-1:0] tgt;
  } entry_t;

  localparam logic signed [32:0] PMAX = (33'sd1 <<< (POS_WIDTH - 1)) - 33'sd1;
  localparam logic signed [32:0] PMIN = -PMAX - 33'sd1;

  entry_t             in_d, out_q;
  logic signed [32:0] tgt_ext;

  always_comb begin
    in_d.ctl.sense  = sense_level_i;
    // motion code three means stopped
    in_d.ctl.motion = (new_motion_i == 2'd3) ? MOT_STOP : new_motion_i;
    case (mode_i)
      MODE_TICK:   in_d.ctl.op = OP_TICK;
      MODE_TARGET: in_d.ctl.op = OP_TARGET;
      MODE_MOTION: in_d.ctl.op = OP_MOTION;
      MODE_LIMIT:  in_d.ctl.op = OP_LIMIT;
      MODE_REZERO: in_d.ctl.op = OP_REZERO;
      default:     in_d.ctl.op = OP_NOP;
    endcase
    tgt_ext = 33'(target_value_i);
    if (tgt_ext > PMAX) begin
      in_d.tgt = PMAX[POS_WIDTH-1:0];
    end else if (tgt_ext < PMIN) begin
      in_d.tgt = PMIN[POS_WIDTH-1:0];
    end else begin
      in_d.tgt = tgt_ext[POS_WIDTH-1:0];
    end
  end

  pcps_fifo #(
    .T     (entry_t),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (in_d),
    .full_o  (full_o),
    .pop_i   (pop_i),
    .data_o  (out_q),
    .empty_o (empty_o)
  );

  assign ctl_o = out_q.ctl;
  assign tgt_o = out_q.tgt;

endmodule

### hw/rtl/pcps_back.sv
// Back end: holds the controller state and carries out one request per cycle while the result queue is not full.
// Depends on pcps_pkg.
module pcps_back
  import pcps_pkg::*;
#(
  parameter int unsigned POS_WIDTH = POS_WIDTH_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  cmd_ctl_t                    ctl_i,
  input  logic signed [POS_WIDTH-1:0] tgt_i,
  input  logic                        res_full_i,
  output logic                        cmd_take_o,
  output res_flags_t                  flags_o,
  output logic signed [POS_WIDTH-1:0] position_o,
  output logic signed [POS_WIDTH-1:0] target_o,
  output logic                        target_set_o,
  output logic signed [POS_WIDTH-1:0] limit_o
);

  localparam logic signed [POS_WIDTH-1:0] PMAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [POS_WIDTH-1:0] PMIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

  logic [1:0]                  motion_q, motion_d;
  logic                        sense_q, sense_d;
  logic signed [POS_WIDTH-1:0] pos_q, pos_d;
  logic signed [POS_WIDTH-1:0] tgt_q, tgt_d;
  logic                        tvalid_q, tvalid_d;
  logic signed [POS_WIDTH-1:0] lim_q, lim_d;

  logic signed [POS_WIDTH-1:0] pos_step;
  logic signed [POS_WIDTH:0]   lim_diff, tgt_diff;
  logic signed [POS_WIDTH-1:0] lim_sat, tgt_sat;
  res_flags_t                  fl;

  assign cmd_take_o = cmd_valid_i && !res_full_i;

  always_comb begin
    // saturated one-step move in the current direction
    if (motion_q == MOT_DEC) begin
      pos_step = (pos_q == PMIN) ? pos_q : pos_q - 1'b1;
    end else begin
      pos_step = (pos_q == PMAX) ? pos_q : pos_q + 1'b1;
    end

    lim_diff = {lim_q[POS_WIDTH-1], lim_q} - {pos_q[POS_WIDTH-1], pos_q};
    tgt_diff = {tgt_q[POS_WIDTH-1], tgt_q} - {pos_q[POS_WIDTH-1], pos_q};
    if (lim_diff[POS_WIDTH] != lim_diff[POS_WIDTH-1]) begin
      lim_sat = lim_diff[POS_WIDTH] ? PMIN : PMAX;
    end else begin
      lim_sat = lim_diff[POS_WIDTH-1:0];
    end
    if (tgt_diff[POS_WIDTH] != tgt_diff[POS_WIDTH-1]) begin
      tgt_sat = tgt_diff[POS_WIDTH] ? PMIN : PMAX;
    end else begin
      tgt_sat = tgt_diff[POS_WIDTH-1:0];
    end

    motion_d = motion_q;
    sense_d  = sense_q;
    pos_d    = pos_q;
    tgt_d    = tgt_q;
    tvalid_d = tvalid_q;
    lim_d    = lim_q;
    fl       = '0;

    case (ctl_i.op)
      OP_TICK: begin
        if (motion_q != MOT_STOP) begin
          fl.moving = 1'b1;
          if (ctl_i.sense != sense_q) begin
            sense_d   = ctl_i.sense;
            pos_d     = pos_step;
            fl.pos_ev = 1'b1;
          end
          if (tvalid_q && ((motion_q == MOT_INC && pos_d >= tgt_q) ||
                           (motion_q == MOT_DEC && pos_d <= tgt_q))) begin
            motion_d  = MOT_STOP;
            fl.mot_ev = 1'b1;
          end
        end
      end
      OP_TARGET: begin
        tgt_d     = tgt_i;
        tvalid_d  = 1'b1;
        fl.tgt_ev = 1'b1;
        if (tgt_i > pos_q) begin
          motion_d  = MOT_INC;
          fl.mot_ev = 1'b1;
        end else if (tgt_i < pos_q) begin
          motion_d  = MOT_DEC;
          fl.mot_ev = 1'b1;
        end
      end
      OP_MOTION: begin
        tvalid_d = 1'b0;
        tgt_d    = '0;
        if (motion_q != ctl_i.motion) begin
          motion_d  = ctl_i.motion;
          fl.mot_ev = 1'b1;
        end
      end
      OP_LIMIT: begin
        lim_d     = pos_q;
        fl.lim_ev = LEV_LIMIT;
      end
      OP_REZERO: begin
        lim_d = lim_sat;
        if (tvalid_q) begin
          tgt_d = tgt_sat;
        end
        pos_d     = '0;
        fl.lim_ev = LEV_REZERO;
      end
      default: begin
      end
    endcase
    fl.motion = motion_d;
  end

  assign flags_o      = fl;
  assign position_o   = pos_d;
  assign target_o     = tvalid_d ? tgt_d : '0;
  assign target_set_o = tvalid_d;
  assign limit_o      = lim_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motion_q <= MOT_STOP;
      sense_q  <= 1'b0;
      pos_q    <= '0;
      tgt_q    <= '0;
      tvalid_q <= 1'b0;
      lim_q    <= '0;
    end else if (cmd_take_o) begin
      motion_q <= motion_d;
      sense_q  <= sense_d;
      pos_q    <= pos_d;
      tgt_q    <= tgt_d;
      tvalid_q <= tvalid_d;
      lim_q    <= lim_d;
    end
  end

endmodule

### hw/rtl/pulse_count_position_stop_controller_top.sv
// Pulse-counting blind position controller, top level. One request (tick or
// command) is taken per clock cycle while the result queue has room; its result
// reaches the result ports through two queues: the request is held in the
// request queue while the execute stage works it out, and the result is then
// written into the result queue. The execute stage
// updates position, target, limit and motion state combinationally, so it
// never limits throughput. Two requests queue up in front and two results
// behind before full is raised. Position, target and limit are POS_WIDTH-bit
// signed values that saturate at their range.
// Depends on pcps_pkg, pcps_fifo, pcps_front and pcps_back.
module pulse_count_position_stop_controller_top
  import pcps_pkg::*;
#(
  parameter int unsigned POS_WIDTH = POS_WIDTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [2:0]                        mode_i,
  input  logic                              sense_level_i,
  input  logic signed [TARGET_IN_WIDTH-1:0] target_value_i,
  input  logic [1:0]                        new_motion_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [POS_WIDTH-1:0]       position_now_o,
  output logic signed [POS_WIDTH-1:0]       target_now_o,
  output logic                              target_set_o,
  output logic signed [POS_WIDTH-1:0]       limit_now_o,
  output logic [1:0]                        motion_now_o,
  output logic                              drive_up_o,
  output logic                              drive_down_o,
  output logic                              moving_flag_o,
  output logic                              position_event_o,
  output logic                              motion_event_o,
  output logic                              target_event_o,
  output logic [1:0]                        limit_event_o
);

  typedef struct packed {
    res_flags_t                  flags;
    logic signed [POS_WIDTH-1:0] pos;
    logic signed [POS_WIDTH-1:0] tgt;
    logic                        tset;
    logic signed [POS_WIDTH-1:0] lim;
  } res_t;

  cmd_ctl_t                    ctl;
  logic signed [POS_WIDTH-1:0] cmd_tgt;
  logic                        cmd_empty, cmd_take, res_full;
  res_t                        res_d, res_q;

  pcps_front #(
    .POS_WIDTH (POS_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .mode_i         (mode_i),
    .sense_level_i  (sense_level_i),
    .target_value_i (target_value_i),
    .new_motion_i   (new_motion_i),
    .pop_i          (cmd_take),
    .empty_o        (cmd_empty),
    .ctl_o          (ctl),
    .tgt_o          (cmd_tgt)
  );

  pcps_back #(
    .POS_WIDTH (POS_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (!cmd_empty),
    .ctl_i        (ctl),
    .tgt_i        (cmd_tgt),
    .res_full_i   (res_full),
    .cmd_take_o   (cmd_take),
    .flags_o      (res_d.flags),
    .position_o   (res_d.pos),
    .target_o     (res_d.tgt),
    .target_set_o (res_d.tset),
    .limit_o      (res_d.lim)
  );

  pcps_fifo #(
    .T     (res_t),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_take),
    .data_i  (res_d),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_q),
    .empty_o (empty)
  );

  assign position_now_o   = res_q.pos;
  assign target_now_o     = res_q.tgt;
  assign target_set_o     = res_q.tset;
  assign limit_now_o      = res_q.lim;
  assign motion_now_o     = res_q.flags.motion;
  assign drive_up_o       = (res_q.flags.motion == MOT_DEC);
  assign drive_down_o     = (res_q.flags.motion == MOT_INC);
  assign moving_flag_o    = res_q.flags.moving;
  assign position_event_o = res_q.flags.pos_ev;
  assign motion_event_o   = res_q.flags.mot_ev;
  assign target_event_o   = res_q.flags.tgt_ev;
  assign limit_event_o    = res_q.flags.lim_ev;

endmodule

### sim/pulse_count_position_stop_controller_top_tb.sv
// Self-checking bench for pulse_count_position_stop_controller_top: a directed table,
// random requests and short counting walks with saturating re-zero, checked against a
// built-in predictor. Depends on pcps_pkg and the controller RTL only.
module pulse_count_position_stop_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcps_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int POS_W         = POS_WIDTH_DEFAULT;
  localparam int POS_MAX       = 2 ** (POS_W - 1) - 1;
  localparam int POS_MIN       = -POS_MAX - 1;
  localparam int RANDOM_ITEMS  = 700;
  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 8;
  localparam int SWEEP_EDGES   = 40;
  localparam int DIR_ROWS      = 25;

  // mode codes with no operation, and the motion code decoded as stopped
  localparam logic [2:0] MODE_NOP_FIRST = 3'd5;
  localparam logic [2:0] MODE_NOP_LAST  = 3'd7;
  localparam logic [1:0] MOT_UNDEF      = 2'd3;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic signed [POS_W-1:0] target;
    logic                    target_set;
    logic signed [POS_W-1:0] limit;
    logic [1:0]              motion;
    logic                    drive_up;
    logic                    drive_down;
    logic                    moving;
    logic                    pos_ev;
    logic                    mot_ev;
    logic                    tgt_ev;
    logic [1:0]              lim_ev;
  } blind_status_t;

  typedef struct packed {
    logic [2:0]                        mode;
    logic                              sense;
    logic signed [TARGET_IN_WIDTH-1:0] tval;
    logic [1:0]                        nm;
    logic                              pinned;
    blind_status_t                     want;
  } dir_row_t;

  logic                              clk_i          = 1'b0;
  logic                              rst_ni         = 1'b0;
  logic                              push           = 1'b0;
  logic                              pop            = 1'b0;
  logic [2:0]                        mode_i         = '0;
  logic                              sense_level_i  = 1'b0;
  logic signed [TARGET_IN_WIDTH-1:0] target_value_i = '0;
  logic [1:0]                        new_motion_i   = '0;
  logic                              full;
  logic                              empty;
  logic signed [POS_W-1:0]           position_now_o;
  logic signed [POS_W-1:0]           target_now_o;
  logic                              target_set_o;
  logic signed [POS_W-1:0]           limit_now_o;
  logic [1:0]                        motion_now_o;
  logic                              drive_up_o;
  logic                              drive_down_o;
  logic                              moving_flag_o;
  logic                              position_event_o;
  logic                              motion_event_o;
  logic                              target_event_o;
  logic [1:0]                        limit_event_o;

  // predicted blind state
  logic [1:0] bl_motion     = MOT_STOP;
  logic       bl_last_sense = 1'b0;
  logic       bl_tgt_valid  = 1'b0;
  int         bl_pos        = 0;
  int         bl_tgt        = 0;
  int         bl_lim        = 0;

  blind_status_t status_q[$];
  int            err_count   = 0;
  bit            calm        = 1'b0;
  int            hold_asked  = 0;
  int            hold_served = 0;
  int            hold_left   = 0;
  int            stall_left  = 0;
  blind_status_t seen;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{MODE_TICK,      1'b1, 16'sd0,    MOT_STOP,  1'b1, '0},
    '{MODE_NOP_FIRST, 1'b0, 16'sh7FFF, MOT_UNDEF, 1'b1, '0},
    '{MODE_NOP_LAST,  1'b1, 16'sh8000, MOT_UNDEF, 1'b1, '0},
    '{MODE_MOTION,    1'b0, 16'sd0,    MOT_UNDEF, 1'b1, '0},
    '{MODE_TARGET,    1'b0, 16'sd0,    MOT_STOP,  1'b1,
      '{16'sd0, 16'sd0, 1'b1, 16'sd0, MOT_STOP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, LEV_NONE}},
    '{MODE_TICK,      1'b1, 16'sd0,    MOT_STOP,  1'b1,
      '{16'sd0, 16'sd0, 1'b1, 16'sd0, MOT_STOP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, LEV_NONE}},
    '{MODE_TARGET,    1'b0, 16'sd3,    MOT_STOP,  1'b1,
      '{16'sd0, 16'sd3, 1'b1, 16'sd0, MOT_INC, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, LEV_NONE}},
    '{MODE_TICK,      1'b1, 16'sd0,    MOT_STOP,  1'b0, '0},
    '{MODE_TICK,      1'b1, 16'sd0,    MOT_STOP,  1'b0, '0},
    '{MODE_TICK,      1'b0, 16'sd0,    MOT_STOP,  1'b0, '0},
    '{MODE_TICK,      1'b1, 16'sd0,    MOT_STOP,  1'b0, '0},
    '{MODE_TICK,      1'b0, 16'sd0,    MOT_STOP,  1'b0, '0},
    '{MODE_LIMIT,     1'b0, 16'sd0,    MOT_STOP,  1'b0, '0},
    '{MODE_TARGET,    1'b0, -16'sd1,   MOT_STOP,  1'b0, '0},
    '{MODE_TICK,      1'b0, 16'sd0,    MOT_STOP,  1'b0, '0},
    '{MODE_TICK,      1'b1, 16'sd0,    MOT_STOP,  1'b0, '0},
    '{MODE_TICK,      1'b0, 16'sd0,    MOT_STOP,  1'b0, '0},
    '{MODE_TICK,      1'b1, 16'sd0,    MOT_STOP,  1'b0, '0},
    '{MODE_REZERO,    1'b0, 16'sd0,    MOT_STOP,  1'b0, '0},
    '{MODE_MOTION,    1'b0, 16'sd0,    MOT_DEC,   1'b0, '0},
    '{MODE_TICK,      1'b0, 16'sd0,    MOT_STOP,  1'b0, '0},
    '{MODE_TARGET,    1'b0, 16'sh7FFF, MOT_STOP,  1'b0, '0},
    '{MODE_TARGET,    1'b0, 16'sh8000, MOT_STOP,  1'b0, '0},
    '{MODE_MOTION,    1'b0, 16'sd0,    MOT_UNDEF, 1'b0, '0},
    '{MODE_MOTION,    1'b0, 16'sd0,    MOT_STOP,  1'b0, '0}
  };

  pulse_count_position_stop_controller_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .mode_i           (mode_i),
    .sense_level_i    (sense_level_i),
    .target_value_i   (target_value_i),
    .new_motion_i     (new_motion_i),
    .empty            (empty),
    .pop              (pop),
    .position_now_o   (position_now_o),
    .target_now_o     (target_now_o),
    .target_set_o     (target_set_o),
    .limit_now_o      (limit_now_o),
    .motion_now_o     (motion_now_o),
    .drive_up_o       (drive_up_o),
    .drive_down_o     (drive_down_o),
    .moving_flag_o    (moving_flag_o),
    .position_event_o (position_event_o),
    .motion_event_o   (motion_event_o),
    .target_event_o   (target_event_o),
    .limit_event_o    (limit_event_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int clamp_pos(int v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  // Apply one request to the predicted state and return the status it produces.
  function automatic blind_status_t advance_blind(logic [2:0] mode, logic sense,
                                                  logic signed [TARGET_IN_WIDTH-1:0] tval,
                                                  logic [1:0] nm);
    blind_status_t s;
    logic [1:0]    forced;
    s      = '0;
    forced = (nm == MOT_UNDEF) ? MOT_STOP : nm;
    case (mode)
      MODE_TICK: begin
        if (bl_motion != MOT_STOP) begin
          s.moving = 1'b1;
          if (sense != bl_last_sense) begin
            bl_last_sense = sense;
            bl_pos        = clamp_pos(bl_pos + ((bl_motion == MOT_DEC) ? -1 : 1));
            s.pos_ev      = 1'b1;
          end
          // stop on reaching the target, keep the target active
          if (bl_tgt_valid && ((bl_motion == MOT_INC && bl_pos >= bl_tgt) ||
                               (bl_motion == MOT_DEC && bl_pos <= bl_tgt))) begin
            bl_motion = MOT_STOP;
            s.mot_ev  = 1'b1;
          end
        end
      end
      MODE_TARGET: begin
        bl_tgt       = clamp_pos(int'(tval));
        bl_tgt_valid = 1'b1;
        s.tgt_ev     = 1'b1;
        if (bl_tgt != bl_pos) begin
          bl_motion = (bl_tgt > bl_pos) ? MOT_INC : MOT_DEC;
          s.mot_ev  = 1'b1;
        end
      end
      MODE_MOTION: begin
        bl_tgt_valid = 1'b0;
        bl_tgt       = 0;
        if (bl_motion != forced) begin
          bl_motion = forced;
          s.mot_ev  = 1'b1;
        end
      end
      MODE_LIMIT: begin
        bl_lim   = bl_pos;
        s.lim_ev = LEV_LIMIT;
      end
      MODE_REZERO: begin
        bl_lim = clamp_pos(bl_lim - bl_pos);
        if (bl_tgt_valid) bl_tgt = clamp_pos(bl_tgt - bl_pos);
        bl_pos   = 0;
        s.lim_ev = LEV_REZERO;
      end
      default: ;
    endcase
    s.position   = bl_pos[POS_W-1:0];
    s.target     = bl_tgt_valid ? bl_tgt[POS_W-1:0] : '0;
    s.target_set = bl_tgt_valid;
    s.limit      = bl_lim[POS_W-1:0];
    s.motion     = bl_motion;
    s.drive_up   = (bl_motion == MOT_DEC);
    s.drive_down = (bl_motion == MOT_INC);
    return s;
  endfunction

  task automatic flag_error(string msg);
    err_count++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) flag_error($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic compare_status(blind_status_t got, blind_status_t want);
    check_field("position_now", int'($signed(got.position)), int'($signed(want.position)));
    check_field("target_now", int'($signed(got.target)), int'($signed(want.target)));
    check_field("target_set", int'(got.target_set), int'(want.target_set));
    check_field("limit_now", int'($signed(got.limit)), int'($signed(want.limit)));
    check_field("motion_now", int'(got.motion), int'(want.motion));
    check_field("drive_up", int'(got.drive_up), int'(want.drive_up));
    check_field("drive_down", int'(got.drive_down), int'(want.drive_down));
    check_field("moving_flag", int'(got.moving), int'(want.moving));
    check_field("position_event", int'(got.pos_ev), int'(want.pos_ev));
    check_field("motion_event", int'(got.mot_ev), int'(want.mot_ev));
    check_field("target_event", int'(got.tgt_ev), int'(want.tgt_ev));
    check_field("limit_event", int'(got.lim_ev), int'(want.lim_ev));
  endtask

  // Offer one request, hold it until accepted, then record its predicted status, or the pinned one if given.
  task automatic send_request(logic [2:0] mode, logic sense,
                              logic signed [TARGET_IN_WIDTH-1:0] tval, logic [1:0] nm,
                              bit pinned = 1'b0, blind_status_t pinned_want = '0);
    blind_status_t predicted;
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    push           <= 1'b1;
    mode_i         <= mode;
    sense_level_i  <= sense;
    target_value_i <= tval;
    new_motion_i   <= nm;
    do @(posedge clk_i); while (full);
    predicted = advance_blind(mode, sense, tval, nm);
    status_q.push_back(pinned ? pinned_want : predicted);
  endtask

  // Count n sense edges in the current direction.
  task automatic drive_ticks(int n);
    for (int k = 0; k < n; k++) begin
      send_request(MODE_TICK, ~bl_last_sense, TARGET_IN_WIDTH'($urandom),
                   2'($urandom_range(0, 3)));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        seen = '{position_now_o, target_now_o, target_set_o, limit_now_o, motion_now_o,
                 drive_up_o, drive_down_o, moving_flag_o, position_event_o, motion_event_o,
                 target_event_o, limit_event_o};
        if (status_q.size() == 0) flag_error("result with no request pending");
        else compare_status(seen, status_q.pop_front());
      end
      if (hold_served != hold_asked) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      // hold off long enough to back the block up into full
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 7);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int                                pick;
    int                                near;
    logic [2:0]                        md;
    logic                              sn;
    logic signed [TARGET_IN_WIDTH-1:0] tv;
    logic [1:0]                        nm;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      send_request(dir_tab[i].mode, dir_tab[i].sense, dir_tab[i].tval, dir_tab[i].nm,
                   dir_tab[i].pinned, dir_tab[i].want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) hold_asked++;
      sn   = 1'($urandom_range(0, 1));
      tv   = TARGET_IN_WIDTH'($urandom);
      nm   = 2'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        md = MODE_TICK;
        if ($urandom_range(0, 3) != 0) sn = ~bl_last_sense;
      end else if (pick < 70) begin
        md = MODE_TARGET;
        // aim close by most of the time so the motor reaches its target
        if ($urandom_range(0, 3) != 0) begin
          near = bl_pos + int'($urandom_range(0, 16)) - 8;
          tv   = TARGET_IN_WIDTH'(clamp_pos(near));
        end
      end else if (pick < 80) begin
        md = MODE_MOTION;
      end else if (pick < 85) begin
        md = MODE_LIMIT;
      end else if (pick < 90) begin
        md = MODE_REZERO;
      end else if (pick < 95) begin
        md = 3'($urandom_range(MODE_NOP_FIRST, MODE_NOP_LAST));
      end else begin
        md = 3'($urandom_range(0, 7));
      end
      send_request(md, sn, tv, nm);
    end

    // Walk the position both ways, then re-zero against an extreme target so it saturates.
    calm = 1'b1;
    send_request(MODE_REZERO, 1'b0, '0, MOT_STOP);
    for (int leg = 0; leg < 2; leg++) begin
      send_request(MODE_MOTION, 1'b0, '0, leg ? MOT_DEC : MOT_INC);
      drive_ticks(5);
      send_request(MODE_LIMIT, 1'b0, '0, MOT_STOP);
      send_request(MODE_MOTION, 1'b0, '0, leg ? MOT_INC : MOT_DEC);
      drive_ticks(SWEEP_EDGES);
      send_request(MODE_TARGET, 1'b0, leg ? 16'sh8000 : 16'sh7FFF, MOT_STOP);
      send_request(MODE_REZERO, 1'b0, '0, MOT_STOP);
    end
    push <= 1'b0;

    while (status_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("pulse_count_position_stop_controller_top_tb: PASS");
    end else begin
      $display("pulse_count_position_stop_controller_top_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("pulse_count_position_stop_controller_top_tb: FAIL");
    $finish;
  end

endmodule
